// ===== rtl/toeq_pkg.sv =====
`timescale 1ns / 1ps
package toeq_pkg;

  // Fixed field widths of the request and result items
  localparam int FIELD_TIME_W = 40;
  localparam int KIND_W       = 3;
  localparam int IDENT_W      = 16;
  localparam int LINE_W       = 8;
  localparam int OCC_W        = 7;
  localparam int STATUS_W     = 3;

  // Configuration port
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 64;
  localparam logic [APB_ADDR_W-1:0] REG_HORIZON_ADDR = 4'h0;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_PULL   = 1'b1
  } req_type_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED     = 3'd0,
    ST_DROP_HORIZON = 3'd1,
    ST_DROP_FULL    = 3'd2,
    ST_PULLED       = 3'd3,
    ST_END_EVENT    = 3'd4
  } status_t;

  // Everything an event carries besides its time
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [IDENT_W-1:0] ident;
    logic [LINE_W-1:0]  line;
  } event_tag_t;

  // Per-cell load selection for one cycle
  typedef struct packed {
    logic load_new;
    logic shift_prev;
    logic shift_next;
  } cell_ctrl_t;

endpackage

// ===== rtl/toeq_if.sv =====
`timescale 1ns / 1ps
interface toeq_req_if import toeq_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    req_type;
  logic [FIELD_TIME_W-1:0] event_time;
  logic [KIND_W-1:0]       event_kind;
  logic [IDENT_W-1:0]      event_ident;
  logic [LINE_W-1:0]       line_number;

  modport source (
    output valid, req_type, event_time, event_kind, event_ident, line_number,
    input  ready
  );
  modport sink (
    input  valid, req_type, event_time, event_kind, event_ident, line_number,
    output ready
  );
endinterface

interface toeq_rsp_if import toeq_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic [FIELD_TIME_W-1:0] out_time;
  logic [KIND_W-1:0]       out_kind;
  logic [IDENT_W-1:0]      out_ident;
  logic [LINE_W-1:0]       out_line;
  logic [OCC_W-1:0]        occupancy;

  modport source (
    output valid, status, out_time, out_kind, out_ident, out_line, occupancy,
    input  ready
  );
  modport sink (
    input  valid, status, out_time, out_kind, out_ident, out_line, occupancy,
    output ready
  );
endinterface

// ===== rtl/time_ordered_event_queue.sv =====
`timescale 1ns / 1ps
// Time-ordered event queue. Events sit in a row of QUEUE_DEPTH cells sorted by
// ascending time, the earliest in cell 0. Every cell compares its own time with
// the time of an incoming insert in the same cycle, so the block takes one
// request (insert or pull) per clock and presents its result on rsp in the cycle
// after the transfer; req.ready follows rsp.ready through the single output
// register, so a stalled result holds off only the next request. An insert lands
// in front of the first stored event with a strictly later time, so equal times
// leave in arrival order. Inserts with a time at or past the horizon register are
// dropped (status 1) before the full check (status 2). A pull on an empty queue
// returns an end-of-simulation event at the horizon time (status 4). Insert
// results carry zero event fields. Cells beyond the occupancy hold stale data and
// need no clearing after reset. The horizon register sits at APB address 0.
module time_ordered_event_queue import toeq_pkg::*; #(
  parameter int QUEUE_DEPTH = 64,
  parameter int TIME_BITS   = 40
) (
  input  logic                  clk,
  input  logic                  rst,
  toeq_req_if.sink              req,
  toeq_rsp_if.source            rsp,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  // ---------------------------------------------------------------------------
  // Configuration: horizon register
  // ---------------------------------------------------------------------------
  logic [TIME_BITS-1:0] horizon;
  logic                 cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr == REG_HORIZON_ADDR);

  always_ff @(posedge clk) begin
    if (rst) begin
      horizon <= '0;
    end else if (cfg_write) begin
      horizon <= TIME_BITS'(pwdata[FIELD_TIME_W-1:0]);
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == REG_HORIZON_ADDR) begin
      prdata = APB_DATA_W'(FIELD_TIME_W'(horizon));
    end
  end

  // ---------------------------------------------------------------------------
  // Request decode
  // ---------------------------------------------------------------------------
  logic                 req_xfer;
  logic [TIME_BITS-1:0] new_time;
  event_tag_t           new_tag;
  logic                 is_pull;
  logic                 past_horizon;
  logic                 is_full;
  logic                 is_empty;
  logic                 do_insert;
  logic                 do_pull;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;

  // A new request may transfer whenever the output register is free or drains
  assign req.ready = !rsp.valid || rsp.ready;
  assign req_xfer  = req.valid && req.ready;

  assign new_time      = TIME_BITS'(req.event_time);
  assign new_tag.kind  = req.event_kind;
  assign new_tag.ident = req.event_ident;
  assign new_tag.line  = req.line_number;

  assign is_pull      = (req.req_type == REQ_PULL);
  assign past_horizon = (new_time >= horizon);
  assign is_full      = (count == CNT_FULL);
  assign is_empty     = (count == '0);

  assign do_insert = req_xfer && !is_pull && !past_horizon && !is_full;
  assign do_pull   = req_xfer && is_pull && !is_empty;

  always_comb begin
    count_next = count;
    if (do_insert) begin
      count_next = count + CNT_W'(1);
    end else if (do_pull) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Cell row: insert shifts the tail right from the insertion point, pull
  // shifts the whole row left by one
  // ---------------------------------------------------------------------------
  logic [TIME_BITS-1:0] cell_time [QUEUE_DEPTH];
  event_tag_t           cell_tag  [QUEUE_DEPTH];
  logic                 after     [QUEUE_DEPTH];
  cell_ctrl_t           ctrl      [QUEUE_DEPTH];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                 after_prev;
    logic                 occupied;
    logic [TIME_BITS-1:0] prev_time;
    event_tag_t           prev_tag;
    logic [TIME_BITS-1:0] next_time;
    event_tag_t           next_tag;

    if (i == 0) begin : g_head
      assign after_prev = 1'b0;
      assign prev_time  = new_time;
      assign prev_tag   = new_tag;
    end else begin : g_body
      assign after_prev = after[i-1];
      assign prev_time  = cell_time[i-1];
      assign prev_tag   = cell_tag[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      // Nothing beyond the last cell; hold its stale contents on a pull
      assign next_time = cell_time[i];
      assign next_tag  = cell_tag[i];
    end else begin : g_inner
      assign next_time = cell_time[i+1];
      assign next_tag  = cell_tag[i+1];
    end

    assign occupied = (CNT_W'(i) < count);

    // First cell past the insertion point takes the new event, later ones
    // take their left neighbor
    assign ctrl[i].load_new   = do_insert && after[i] && !after_prev;
    assign ctrl[i].shift_prev = do_insert && after[i] && after_prev;
    assign ctrl[i].shift_next = do_pull;

    toeq_cell #(
      .TIME_BITS (TIME_BITS)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl[i]),
      .occupied  (occupied),
      .new_time  (new_time),
      .new_tag   (new_tag),
      .prev_time (prev_time),
      .prev_tag  (prev_tag),
      .next_time (next_time),
      .next_tag  (next_tag),
      .cell_time (cell_time[i]),
      .cell_tag  (cell_tag[i]),
      .after     (after[i])
    );
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  status_t                 status_next;
  logic [FIELD_TIME_W-1:0] time_next;
  event_tag_t              tag_next;

  always_comb begin
    status_next = ST_INSERTED;
    time_next   = '0;
    tag_next    = '0;
    if (is_pull) begin
      if (is_empty) begin
        status_next = ST_END_EVENT;
        time_next   = FIELD_TIME_W'(horizon);
      end else begin
        status_next = ST_PULLED;
        time_next   = FIELD_TIME_W'(cell_time[0]);
        tag_next    = cell_tag[0];
      end
    end else if (past_horizon) begin
      status_next = ST_DROP_HORIZON;
    end else if (is_full) begin
      status_next = ST_DROP_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (req_xfer) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  // Load the payload on every request transfer; it holds while stalled
  always_ff @(posedge clk) begin
    if (req_xfer) begin
      rsp.status    <= status_next;
      rsp.out_time  <= time_next;
      rsp.out_kind  <= tag_next.kind;
      rsp.out_ident <= tag_next.ident;
      rsp.out_line  <= tag_next.line;
      rsp.occupancy <= OCC_W'(count_next);
    end
  end

endmodule

// ===== rtl/toeq_cell.sv =====
`timescale 1ns / 1ps
module toeq_cell import toeq_pkg::*; #(
  parameter int TIME_BITS
) (
  input  logic                 clk,
  input  cell_ctrl_t           ctrl,
  input  logic                 occupied,
  input  logic [TIME_BITS-1:0] new_time,
  input  event_tag_t           new_tag,
  input  logic [TIME_BITS-1:0] prev_time,
  input  event_tag_t           prev_tag,
  input  logic [TIME_BITS-1:0] next_time,
  input  event_tag_t           next_tag,
  output logic [TIME_BITS-1:0] cell_time,
  output event_tag_t           cell_tag,
  output logic                 after
);

  // The new event belongs in front of this cell (or the cell is free)
  assign after = !occupied || (cell_time > new_time);

  always_ff @(posedge clk) begin
    if (ctrl.load_new) begin
      cell_time <= new_time;
      cell_tag  <= new_tag;
    end else if (ctrl.shift_prev) begin
      cell_time <= prev_time;
      cell_tag  <= prev_tag;
    end else if (ctrl.shift_next) begin
      cell_time <= next_time;
      cell_tag  <= next_tag;
    end
  end

endmodule

// ===== test/time_ordered_event_queue_test.sv =====
`timescale 1ns / 1ps
module time_ordered_event_queue_test;
  import toeq_pkg::*;

  localparam int QUEUE_CAPACITY = 64;
  localparam logic [FIELD_TIME_W-1:0] HZ_MAX = '1;
  localparam logic [FIELD_TIME_W-1:0] T_HI   = HZ_MAX - 1;
  localparam int SEGMENTS      = 6;
  localparam int SEGMENT_ITEMS = 90;
  localparam int BLOCK_ITEMS   = 24;

  // One request transfer as the sender sees it
  typedef struct packed {
    req_type_t               op;
    logic [FIELD_TIME_W-1:0] at;
    event_tag_t              tag;
  } queue_request_t;

  // One result transfer, field for field as on rsp
  typedef struct packed {
    status_t                 status;
    logic [FIELD_TIME_W-1:0] at;
    event_tag_t              tag;
    logic [OCC_W-1:0]        occupancy;
  } queue_result_t;

  // One event held in the sorted schedule
  typedef struct packed {
    logic [FIELD_TIME_W-1:0] at;
    event_tag_t              tag;
  } stored_event_t;

  // Directed stimulus row: optional horizon write first, then one request.
  // Where has_answer is set, the result below is taken as given; otherwise the
  // schedule model supplies it. Event fields of a given result are all zero.
  typedef struct packed {
    logic                    set_horizon;
    logic [FIELD_TIME_W-1:0] horizon;
    req_type_t               op;
    logic [FIELD_TIME_W-1:0] at;
    logic [KIND_W-1:0]       kind;
    logic [IDENT_W-1:0]      ident;
    logic [LINE_W-1:0]       line;
    logic                    has_answer;
    status_t                 want_status;
    logic [FIELD_TIME_W-1:0] want_time;
    logic [OCC_W-1:0]        want_occupancy;
  } directed_row_t;

  localparam directed_row_t DIRECTED_PLAN [21] = '{
    // horizon still at its reset value of zero: empty pull, then a drop
    '{1'b0, 40'd0, REQ_PULL, 40'd0, 3'd0, 16'h0000, 8'h00, 1'b1, ST_END_EVENT, 40'd0, 7'd0},
    '{1'b0, 40'd0, REQ_INSERT, 40'd0, 3'd1, 16'h0001, 8'h01,
      1'b1, ST_DROP_HORIZON, 40'd0, 7'd0},
    // widest horizon: end event carries it, a time equal to it is dropped
    '{1'b1, HZ_MAX, REQ_PULL, 40'd0, 3'd0, 16'h0000, 8'h00, 1'b1, ST_END_EVENT, HZ_MAX, 7'd0},
    '{1'b0, 40'd0, REQ_INSERT, HZ_MAX, 3'd7, 16'hFFFF, 8'hFF,
      1'b1, ST_DROP_HORIZON, 40'd0, 7'd0},
    '{1'b0, 40'd0, REQ_INSERT, T_HI, 3'd7, 16'hFFFF, 8'hFF, 1'b1, ST_INSERTED, 40'd0, 7'd1},
    '{1'b0, 40'd0, REQ_INSERT, 40'd0, 3'd0, 16'h0000, 8'h00, 1'b1, ST_INSERTED, 40'd0, 7'd2},
    // equal times must leave in arrival order
    '{1'b0, 40'd0, REQ_INSERT, 40'h55_5555_5555, 3'd5, 16'hAAAA, 8'h55,
      1'b0, ST_INSERTED, 40'd0, 7'd0},
    '{1'b0, 40'd0, REQ_INSERT, 40'h55_5555_5555, 3'd2, 16'h5555, 8'hAA,
      1'b0, ST_INSERTED, 40'd0, 7'd0},
    '{1'b0, 40'd0, REQ_INSERT, 40'hAA_AAAA_AAAA, 3'd1, 16'h0001, 8'h01,
      1'b0, ST_INSERTED, 40'd0, 7'd0},
    '{1'b0, 40'd0, REQ_INSERT, 40'd0, 3'd6, 16'h1234, 8'h0F, 1'b0, ST_INSERTED, 40'd0, 7'd0},
    // drain all six in time order
    '{1'b0, 40'd0, REQ_PULL, 40'd0, 3'd0, 16'h0000, 8'h00, 1'b0, ST_PULLED, 40'd0, 7'd0},
    '{1'b0, 40'd0, REQ_PULL, 40'd0, 3'd0, 16'h0000, 8'h00, 1'b0, ST_PULLED, 40'd0, 7'd0},
    '{1'b0, 40'd0, REQ_PULL, 40'd0, 3'd0, 16'h0000, 8'h00, 1'b0, ST_PULLED, 40'd0, 7'd0},
    '{1'b0, 40'd0, REQ_PULL, 40'd0, 3'd0, 16'h0000, 8'h00, 1'b0, ST_PULLED, 40'd0, 7'd0},
    '{1'b0, 40'd0, REQ_PULL, 40'd0, 3'd0, 16'h0000, 8'h00, 1'b0, ST_PULLED, 40'd0, 7'd0},
    '{1'b0, 40'd0, REQ_PULL, 40'd0, 3'd0, 16'h0000, 8'h00, 1'b0, ST_PULLED, 40'd0, 7'd0},
    '{1'b0, 40'd0, REQ_PULL, 40'd0, 3'd0, 16'h0000, 8'h00, 1'b1, ST_END_EVENT, HZ_MAX, 7'd0},
    // narrowest useful horizon: only time zero gets in
    '{1'b1, 40'd1, REQ_INSERT, 40'd1, 3'd3, 16'h00FF, 8'h7F,
      1'b1, ST_DROP_HORIZON, 40'd0, 7'd0},
    '{1'b0, 40'd0, REQ_INSERT, 40'd0, 3'd4, 16'hBEEF, 8'h80, 1'b1, ST_INSERTED, 40'd0, 7'd1},
    '{1'b0, 40'd0, REQ_PULL, 40'd0, 3'd0, 16'h0000, 8'h00, 1'b0, ST_PULLED, 40'd0, 7'd0},
    '{1'b0, 40'd0, REQ_PULL, 40'd0, 3'd0, 16'h0000, 8'h00, 1'b1, ST_END_EVENT, 40'd1, 7'd0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  toeq_req_if req_bus ();
  toeq_rsp_if rsp_bus ();

  time_ordered_event_queue #(
    .QUEUE_DEPTH(QUEUE_CAPACITY),
    .TIME_BITS  (FIELD_TIME_W)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .req    (req_bus),
    .rsp    (rsp_bus),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Schedule model: the sorted event list, the horizon copy and the results
  // still owed by the block, oldest first.
  stored_event_t           schedule[$];
  logic [FIELD_TIME_W-1:0] end_time;
  queue_result_t           pending_results[$];

  int mismatch_count     = 0;
  int sender_gap_pct     = 0;
  int receiver_stall_pct = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one accepted request to the schedule model and return its result.
  // Horizon check comes before the full check; inserts land ahead of the
  // first strictly later event so ties keep arrival order.
  function automatic queue_result_t apply_to_schedule(queue_request_t rq);
    queue_result_t res;
    stored_event_t ev;
    int slot;
    int i;
    res = '0;
    if (rq.op == REQ_INSERT) begin
      if (rq.at >= end_time) begin
        res.status = ST_DROP_HORIZON;
      end else if (schedule.size() >= QUEUE_CAPACITY) begin
        res.status = ST_DROP_FULL;
      end else begin
        slot = schedule.size();
        for (i = 0; i < schedule.size(); i++) begin
          if (schedule[i].at > rq.at) begin
            slot = i;
            break;
          end
        end
        ev.at  = rq.at;
        ev.tag = rq.tag;
        schedule.insert(slot, ev);
        res.status = ST_INSERTED;
      end
    end else if (schedule.size() == 0) begin
      // empty pull hands back the end-of-simulation event at the horizon
      res.status = ST_END_EVENT;
      res.at     = end_time;
    end else begin
      ev = schedule.pop_front();
      res.status = ST_PULLED;
      res.at     = ev.at;
      res.tag    = ev.tag;
    end
    res.occupancy = OCC_W'(schedule.size());
    return res;
  endfunction

  // Event times: mostly under the horizon, some copied from stored events to
  // force ties, some right at the horizon edge, some anywhere in 40 bits.
  function automatic logic [FIELD_TIME_W-1:0] pick_event_time();
    logic [63:0] wide;
    int pick;
    wide = {$urandom, $urandom};
    pick = $urandom_range(0, 9);
    if (pick <= 2) return wide[FIELD_TIME_W-1:0];
    if (pick <= 5) return (end_time == 0) ? '0 : FIELD_TIME_W'(wide % end_time);
    if (pick <= 7) begin
      if (schedule.size() == 0) return '0;
      return schedule[$urandom_range(0, schedule.size() - 1)].at;
    end
    if (pick == 8) return (end_time != 0 && wide[0]) ? end_time - 1 : end_time;
    return wide[0] ? HZ_MAX : '0;
  endfunction

  function automatic queue_request_t random_request(int insert_pct);
    queue_request_t rq;
    rq.op        = ($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_PULL;
    rq.at        = pick_event_time();
    rq.tag.kind  = KIND_W'($urandom);
    rq.tag.ident = IDENT_W'($urandom);
    rq.tag.line  = LINE_W'($urandom);
    return rq;
  endfunction

  // Present one request, hold it until the transfer, then log what it owes.
  // Valid stays high straight into the next request unless a gap is drawn.
  task automatic issue_request(queue_request_t rq, bit use_given, queue_result_t given);
    queue_result_t predicted;
    while ($urandom_range(0, 99) < sender_gap_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
    req_bus.valid       <= 1'b1;
    req_bus.req_type    <= rq.op;
    req_bus.event_time  <= rq.at;
    req_bus.event_kind  <= rq.tag.kind;
    req_bus.event_ident <= rq.tag.ident;
    req_bus.line_number <= rq.tag.line;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    predicted = apply_to_schedule(rq);
    pending_results.insert(pending_results.size(), use_given ? given : predicted);
  endtask

  // Drop valid and wait out every owed result plus the output register.
  task automatic wait_until_settled();
    req_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the write lands when pready is seen high.
  task automatic program_horizon(logic [FIELD_TIME_W-1:0] value);
    wait_until_settled();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_HORIZON_ADDR;
    pwdata  <= APB_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    end_time = value;
  endtask

  task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  // Randomly stall the result side; never ready during reset.
  always @(posedge clk) begin
    rsp_bus.ready <= !rst && ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  // Match every result transfer against the oldest owed result.
  always @(posedge clk) begin : result_check
    queue_result_t want;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result transfer, expected none, got status %0d",
                 $time, rsp_bus.status);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, rsp_bus.status);
        check_field("out_time", want.at, rsp_bus.out_time);
        check_field("out_kind", want.tag.kind, rsp_bus.out_kind);
        check_field("out_ident", want.tag.ident, rsp_bus.out_ident);
        check_field("out_line", want.tag.line, rsp_bus.out_line);
        check_field("occupancy", want.occupancy, rsp_bus.occupancy);
      end
    end
  end

  initial begin : stimulus
    queue_request_t          rq;
    queue_result_t           given;
    logic [FIELD_TIME_W-1:0] segment_horizon [SEGMENTS];
    int                      gap_by_mode [3];
    int                      stall_by_mode [3];
    int                      insert_pct;
    int                      seg;
    int                      n;

    // Hold every input at a known value from time zero
    req_bus.valid       <= 1'b0;
    req_bus.req_type    <= REQ_INSERT;
    req_bus.event_time  <= '0;
    req_bus.event_kind  <= '0;
    req_bus.event_ident <= '0;
    req_bus.line_number <= '0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    end_time             = '0;

    gap_by_mode   = '{10, 75, 0};
    stall_by_mode = '{75, 10, 0};

    // Horizon settings for the random segments: widest, tiny, random,
    // widest again, the top bit alone, and a random 16-bit value.
    segment_horizon[0] = HZ_MAX;
    segment_horizon[1] = 40'd48;
    segment_horizon[2] = FIELD_TIME_W'({$urandom, $urandom});
    segment_horizon[3] = HZ_MAX;
    segment_horizon[4] = 40'h80_0000_0000;
    segment_horizon[5] = FIELD_TIME_W'($urandom_range(1, 65535));

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table under the first idle mode
    sender_gap_pct     = gap_by_mode[0];
    receiver_stall_pct = stall_by_mode[0];
    foreach (DIRECTED_PLAN[r]) begin
      if (DIRECTED_PLAN[r].set_horizon) program_horizon(DIRECTED_PLAN[r].horizon);
      rq.op        = DIRECTED_PLAN[r].op;
      rq.at        = DIRECTED_PLAN[r].at;
      rq.tag.kind  = DIRECTED_PLAN[r].kind;
      rq.tag.ident = DIRECTED_PLAN[r].ident;
      rq.tag.line  = DIRECTED_PLAN[r].line;
      given           = '0;
      given.status    = DIRECTED_PLAN[r].want_status;
      given.at        = DIRECTED_PLAN[r].want_time;
      given.occupancy = DIRECTED_PLAN[r].want_occupancy;
      issue_request(rq, DIRECTED_PLAN[r].has_answer, given);
    end

    // Random segments, two per idle mode, each under its own horizon.
    // Blocks of items lean toward inserts or pulls so the schedule swings
    // between empty and full; the widest-horizon segments open with a pure
    // insert run that is longer than the capacity.
    for (seg = 0; seg < SEGMENTS; seg++) begin
      program_horizon(segment_horizon[seg]);
      sender_gap_pct     = gap_by_mode[seg / 2];
      receiver_stall_pct = stall_by_mode[seg / 2];
      insert_pct = 50;
      for (n = 0; n < SEGMENT_ITEMS; n++) begin
        if (n % BLOCK_ITEMS == 0) begin
          if (segment_horizon[seg] == HZ_MAX && n < 3 * BLOCK_ITEMS) begin
            insert_pct = 100;
          end else begin
            case ($urandom_range(0, 2))
              0:       insert_pct = 90;
              1:       insert_pct = 50;
              default: insert_pct = 10;
            endcase
          end
        end
        issue_request(random_request(insert_pct), 1'b0, '0);
      end
    end

    wait_until_settled();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[time_ordered_event_queue] OK");
    end else begin
      $display("[time_ordered_event_queue] ERROR");
    end
    $finish;
  end

  // Hard stop far beyond the slowest correct run
  initial begin : watchdog
    #2_000_000;
    $display("[time_ordered_event_queue] ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/toeq_pkg.sv
rtl/toeq_if.sv
rtl/toeq_cell.sv
rtl/time_ordered_event_queue.sv
test/time_ordered_event_queue_test.sv
